// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the shader source tokenizer: lexer modes,
// token kinds, character codes and the result bundle passed between the
// front and the back.
// ----------------------------------------------------------------------------
package sst_pkg;

	// result queue depth in bundles
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);
	// at most three result items per source byte
	localparam int MaxRes = 3;

	typedef enum logic [3:0] {
		M_IDLE,
		M_SLASH,
		M_COMMENT,
		M_MACRO,
		M_LIT,
		M_IDENT,
		M_LT,
		M_GT,
		M_BAR,
		M_AMP,
		M_EQ
	} mode_t;

	// token kinds
	localparam logic [4:0] K_MACRO    = 5'd0;
	localparam logic [4:0] K_COMMA    = 5'd1;
	localparam logic [4:0] K_SEMI     = 5'd2;
	localparam logic [4:0] K_LPAREN   = 5'd3;
	localparam logic [4:0] K_RPAREN   = 5'd4;
	localparam logic [4:0] K_LBRACKET = 5'd5;
	localparam logic [4:0] K_RBRACKET = 5'd6;
	localparam logic [4:0] K_LBRACE   = 5'd7;
	localparam logic [4:0] K_RBRACE   = 5'd8;
	localparam logic [4:0] K_ADD      = 5'd9;
	localparam logic [4:0] K_SUB      = 5'd10;
	localparam logic [4:0] K_MUL      = 5'd11;
	localparam logic [4:0] K_DIV      = 5'd12;
	localparam logic [4:0] K_REM      = 5'd13;
	localparam logic [4:0] K_LTEQ     = 5'd14;
	localparam logic [4:0] K_LT       = 5'd15;
	localparam logic [4:0] K_GTEQ     = 5'd16;
	localparam logic [4:0] K_GT       = 5'd17;
	localparam logic [4:0] K_LOR      = 5'd18;
	localparam logic [4:0] K_BOR      = 5'd19;
	localparam logic [4:0] K_LAND     = 5'd20;
	localparam logic [4:0] K_BAND     = 5'd21;
	localparam logic [4:0] K_EQEQ     = 5'd22;
	localparam logic [4:0] K_ASSIGN   = 5'd23;
	localparam logic [4:0] K_TERNARY  = 5'd24;
	localparam logic [4:0] K_COLON    = 5'd25;
	localparam logic [4:0] K_DOT      = 5'd26;
	localparam logic [4:0] K_LIT      = 5'd27;
	localparam logic [4:0] K_IDENT    = 5'd28;

	// character codes
	localparam logic [7:0] C_NL    = 8'h0A;
	localparam logic [7:0] C_SLASH = 8'h2F;
	localparam logic [7:0] C_HASH  = 8'h23;
	localparam logic [7:0] C_F     = 8'h66;
	localparam logic [7:0] C_DOT   = 8'h2E;
	localparam logic [7:0] C_UNDER = 8'h5F;
	localparam logic [7:0] C_EQ    = 8'h3D;
	localparam logic [7:0] C_LT    = 8'h3C;
	localparam logic [7:0] C_GT    = 8'h3E;
	localparam logic [7:0] C_BAR   = 8'h7C;
	localparam logic [7:0] C_AMP   = 8'h26;

	// one result item without its run marker
	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] text;
		logic       text_valid;
		logic       tok_end;
	} result_t;

	// all results of one source byte
	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MaxRes-1:0]      res;
	} bundle_t;

	// queue status toward the top and the back
	typedef struct packed {
		logic           empty;
		logic           full;
		logic [QAw:0]   count;
	} q_status_t;

endpackage

// ===== rtl/sst_front.sv =====
// ----------------------------------------------------------------------------
// sst_front
// Lexer front: holds the lexer mode and turns each accepted byte into a
// bundle of zero to three result items.
// ----------------------------------------------------------------------------
module sst_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       char_byte,
	input  logic             end_of_text,
	output sst_pkg::bundle_t bundle
);
	import sst_pkg::*;

	mode_t mode_q;
	mode_t mode_nxt;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic result_t mk(input logic [4:0] kind, input logic [7:0] text,
			input logic tv, input logic te);
		result_t r;
		r.kind       = kind;
		r.text       = text;
		r.text_valid = tv;
		r.tok_end    = te;
		return r;
	endfunction

	// single-byte punctuation lookup
	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] r;
		r = '0;
		case (c)
			8'h2C:   r = {1'b1, K_COMMA};
			8'h3B:   r = {1'b1, K_SEMI};
			8'h28:   r = {1'b1, K_LPAREN};
			8'h29:   r = {1'b1, K_RPAREN};
			8'h5B:   r = {1'b1, K_LBRACKET};
			8'h5D:   r = {1'b1, K_RBRACKET};
			8'h7B:   r = {1'b1, K_LBRACE};
			8'h7D:   r = {1'b1, K_RBRACE};
			8'h2B:   r = {1'b1, K_ADD};
			8'h2D:   r = {1'b1, K_SUB};
			8'h2A:   r = {1'b1, K_MUL};
			8'h25:   r = {1'b1, K_REM};
			8'h3F:   r = {1'b1, K_TERNARY};
			8'h3A:   r = {1'b1, K_COLON};
			8'h2E:   r = {1'b1, K_DOT};
			default: r = '0;
		endcase
		return r;
	endfunction

	// per-byte lexing: mode step, fresh start, end-of-text flush
	always_comb begin
		logic [1:0]  n;
		logic        used;
		logic [7:0]  pb;
		logic [4:0]  kpair;
		logic [4:0]  ksingle;
		logic [5:0]  sk;
		result_t [MaxRes-1:0] res;

		n       = 2'd0;
		used    = 1'b0;
		pb      = C_EQ;
		kpair   = K_EQEQ;
		ksingle = K_ASSIGN;
		res     = '0;
		mode_nxt = M_IDLE;
		sk      = single_kind(char_byte);

		case (mode_q)
			M_COMMENT: begin
				mode_nxt = (char_byte == C_NL) ? M_IDLE : M_COMMENT;
				used = 1'b1;
			end
			M_MACRO: begin
				if (char_byte == C_NL) begin
					res[n] = mk(K_MACRO, 8'h00, 1'b0, 1'b1);
					mode_nxt = M_IDLE;
				end else begin
					res[n] = mk(K_MACRO, char_byte, 1'b1, 1'b0);
					mode_nxt = M_MACRO;
				end
				n = n + 2'd1;
				used = 1'b1;
			end
			M_LIT: begin
				if (is_digit(char_byte) || char_byte == C_DOT) begin
					res[n] = mk(K_LIT, char_byte, 1'b1, 1'b0);
					n = n + 2'd1;
					mode_nxt = M_LIT;
					used = 1'b1;
				end else if (char_byte == C_F) begin
					res[n] = mk(K_LIT, char_byte, 1'b1, 1'b0);
					n = n + 2'd1;
					res[n] = mk(K_LIT, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
					used = 1'b1;
				end else begin
					res[n] = mk(K_LIT, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
				end
			end
			M_IDENT: begin
				if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == C_UNDER
						|| char_byte == C_DOT) begin
					res[n] = mk(K_IDENT, char_byte, 1'b1, 1'b0);
					mode_nxt = M_IDENT;
					used = 1'b1;
				end else begin
					res[n] = mk(K_IDENT, 8'h00, 1'b0, 1'b1);
				end
				n = n + 2'd1;
			end
			M_SLASH: begin
				if (char_byte == C_SLASH) begin
					mode_nxt = M_COMMENT;
					used = 1'b1;
				end else begin
					res[n] = mk(K_DIV, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
				end
			end
			M_LT, M_GT, M_BAR, M_AMP, M_EQ: begin
				case (mode_q)
					M_LT:    begin pb = C_EQ;  kpair = K_LTEQ; ksingle = K_LT;   end
					M_GT:    begin pb = C_EQ;  kpair = K_GTEQ; ksingle = K_GT;   end
					M_BAR:   begin pb = C_BAR; kpair = K_LOR;  ksingle = K_BOR;  end
					M_AMP:   begin pb = C_AMP; kpair = K_LAND; ksingle = K_BAND; end
					default: begin pb = C_EQ;  kpair = K_EQEQ; ksingle = K_ASSIGN; end
				endcase
				used = (char_byte == pb);
				res[n] = mk(used ? kpair : ksingle, 8'h00, 1'b0, 1'b1);
				n = n + 2'd1;
			end
			default: begin
				mode_nxt = M_IDLE;
			end
		endcase

		// byte not taken by the pending token starts afresh
		if (!used) begin
			mode_nxt = M_IDLE;
			if (sk[5]) begin
				res[n] = mk(sk[4:0], 8'h00, 1'b0, 1'b1);
				n = n + 2'd1;
			end else if (char_byte == C_SLASH) begin
				mode_nxt = M_SLASH;
			end else if (char_byte == C_HASH) begin
				mode_nxt = M_MACRO;
			end else if (char_byte == C_LT) begin
				mode_nxt = M_LT;
			end else if (char_byte == C_GT) begin
				mode_nxt = M_GT;
			end else if (char_byte == C_BAR) begin
				mode_nxt = M_BAR;
			end else if (char_byte == C_AMP) begin
				mode_nxt = M_AMP;
			end else if (char_byte == C_EQ) begin
				mode_nxt = M_EQ;
			end else if (is_digit(char_byte)) begin
				res[n] = mk(K_LIT, char_byte, 1'b1, 1'b0);
				n = n + 2'd1;
				mode_nxt = M_LIT;
			end else if (is_alpha(char_byte) || char_byte == C_UNDER) begin
				res[n] = mk(K_IDENT, char_byte, 1'b1, 1'b0);
				n = n + 2'd1;
				mode_nxt = M_IDENT;
			end
		end

		// end of text flushes any pending token
		if (end_of_text) begin
			case (mode_nxt)
				M_SLASH: begin res[n] = mk(K_DIV,    8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_LT:    begin res[n] = mk(K_LT,     8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_GT:    begin res[n] = mk(K_GT,     8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_BAR:   begin res[n] = mk(K_BOR,    8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_AMP:   begin res[n] = mk(K_BAND,   8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_EQ:    begin res[n] = mk(K_ASSIGN, 8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_MACRO: begin res[n] = mk(K_MACRO,  8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_LIT:   begin res[n] = mk(K_LIT,    8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				M_IDENT: begin res[n] = mk(K_IDENT,  8'h00, 1'b0, 1'b1); n = n + 2'd1; end
				default: begin end
			endcase
			mode_nxt = M_IDLE;
		end

		bundle.cnt = n;
		bundle.res = res;
	end

	// lexer mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
		end else if (accept) begin
			mode_q <= mode_nxt;
		end
	end

endmodule

// ===== rtl/sst_queue.sv =====
// ----------------------------------------------------------------------------
// sst_queue
// Short queue of result bundles between the lexer front and the output back.
// ----------------------------------------------------------------------------
module sst_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sst_pkg::bundle_t    push_data,
	input  logic                pop,
	output sst_pkg::bundle_t    head,
	output sst_pkg::q_status_t  status
);
	import sst_pkg::*;

	bundle_t          mem_q [QDepth];
	logic [QAw-1:0]   wr_ptr_q;
	logic [QAw-1:0]   rd_ptr_q;
	logic [QAw:0]     count_q;

	// bundle storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == (QAw+1)'(QDepth));
	assign status.count = count_q;

endmodule

// ===== rtl/sst_back.sv =====
// ----------------------------------------------------------------------------
// sst_back
// Output back: walks the head bundle into the output register, one result
// item per cycle while out_ready allows, and marks each byte's last item.
// ----------------------------------------------------------------------------
module sst_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sst_pkg::bundle_t    head,
	input  sst_pkg::q_status_t  status,
	output logic                pop,
	output logic [1:0]          idx,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [4:0]          token_kind,
	output logic [7:0]          text_byte,
	output logic                text_valid,
	output logic                token_end,
	output logic                run_last
);
	import sst_pkg::*;

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic        load;
	logic        last;
	result_t     cur;
	result_t     res_q;
	logic        run_last_q;

	// pick the current item of the head bundle
	always_comb begin
		cur  = head.res[idx_q];
		last = (idx_q == head.cnt - 2'd1);
		load = !status.empty && (!out_valid_q || out_ready);
		pop  = load && last;
	end

	// item index within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q      <= cur;
			run_last_q <= last;
		end
	end

	assign idx        = idx_q;
	assign out_valid  = out_valid_q;
	assign token_kind = res_q.kind;
	assign text_byte  = res_q.text;
	assign text_valid = res_q.text_valid;
	assign token_end  = res_q.tok_end;
	assign run_last   = run_last_q;

endmodule

// ===== rtl/shader_source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// shader_source_tokenizer
// Streaming lexer for C-like shader source: bytes in, token items out.
//
// Input channel (in_valid/in_ready): one source byte per item, with
// end_of_text on the final byte, which flushes any pending token.
// Output channel (out_valid/out_ready): one token item per transfer. Text
// tokens come as one item per byte and then an end item; punctuation is one
// item. run_last marks the last item caused by one input byte.
// An accepted byte's bundle is written into the result queue, and its first
// item then passes through the output register. A byte is accepted every
// cycle while the result queue has room; each byte produces zero to three
// items, the output side sends one item per cycle while out_ready is high,
// and a four-bundle queue absorbs bytes that give two or three items.
// When the receiver stalls, the output item holds, the queue fills, and
// in_ready drops once it holds four bundles.
// Reset: the lexer returns to idle with no pending token, the queue empties
// and no output item is valid.
// ----------------------------------------------------------------------------
module shader_source_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [7:0]  text_byte,
	output logic        text_valid,
	output logic        token_end,
	output logic        run_last
);
	import sst_pkg::*;

	logic       accept;
	logic       push;
	logic       pop;
	logic [1:0] idx;
	bundle_t    bundle;
	bundle_t    head;
	q_status_t  status;

	// input handshake: take a byte whenever a bundle slot is free
	assign in_ready = !status.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (bundle.cnt != 2'd0);

	// lexer front
	sst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_byte   (char_byte),
		.end_of_text (end_of_text),
		.bundle      (bundle)
	);

	// bundle queue
	sst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	// output back
	sst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.status     (status),
		.pop        (pop),
		.idx        (idx),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.text_byte  (text_byte),
		.text_valid (text_valid),
		.token_end  (token_end),
		.run_last   (run_last)
	);

`ifndef SYNTHESIS
	// queue fill never passes its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= (QAw+1)'(QDepth))
		else $error("bundle queue overfilled");

	// a queued bundle always holds at least one item
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |-> head.cnt != 2'd0)
		else $error("empty bundle in queue");

	// the back never walks past the items of the head bundle
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |-> idx < head.cnt)
		else $error("item index beyond bundle");

	// every item either carries text or closes a token
	a_text_or_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> text_valid != token_end)
		else $error("item neither text nor token end");
`endif

endmodule
